@@ src/dpu_pkg.sv @@
// Shared types, register map and helpers for the depth pixel unprojection unit.
`default_nettype none

package dpu_pkg;

    // Register map: index = paddr[4:2]
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_IMAGE_WIDTH   = 3'd0;
    localparam reg_idx_t REG_SAMPLE_STRIDE = 3'd1;
    localparam reg_idx_t REG_MIN_DEPTH     = 3'd2;
    localparam reg_idx_t REG_MAX_DEPTH     = 3'd3;
    localparam reg_idx_t REG_CENTER_X      = 3'd4;
    localparam reg_idx_t REG_CENTER_Y      = 3'd5;
    localparam reg_idx_t REG_INV_FOCAL_X   = 3'd6;
    localparam reg_idx_t REG_INV_FOCAL_Y   = 3'd7;

    localparam int WIDTH_W  = 13;
    localparam int STRIDE_W = 5;
    localparam int DEPTH_W  = 16;
    localparam int CENTER_W = 16;
    localparam int INVF_W   = 24;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 24;
    localparam int POINT_W  = 32;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [STRIDE_W-1:0] RST_SAMPLE_STRIDE = 5'd1;
    localparam logic [DEPTH_W-1:0]  RST_MIN_DEPTH     = 16'd0;
    localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH     = 16'd65535;
    localparam logic [CENTER_W-1:0] RST_CENTER_X      = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y      = 16'd3840;
    localparam logic [INVF_W-1:0]   RST_INV_FOCAL_X   = 24'd31957;
    localparam logic [INVF_W-1:0]   RST_INV_FOCAL_Y   = 24'd31957;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // Rounded magnitude plus sign -> saturated two's complement coordinate
    function automatic logic [POINT_W-1:0] saturate_point(
        input logic [PROD_W:0] mag,
        input logic            neg
    );
        logic [POINT_W-1:0] res;
        if (neg)
        begin
            if (mag > 49'h0_8000_0000)
                res = 32'h8000_0000;
            else
                res = ~mag[POINT_W-1:0] + 32'd1;
        end
        else
        begin
            if (mag > 49'h0_7FFF_FFFF)
                res = 32'h7FFF_FFFF;
            else
                res = mag[POINT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/depth_pixel_unproject_unit.sv @@
// Top level: raster RGB-D pixel sampler and pinhole unprojection to 3D points.
`default_nettype none

// Pixels arrive in raster order on the pixel channel; a pixel whose row and column
// phases are both zero and whose depth lies strictly between min_depth and max_depth
// (and is nonzero) produces one point transaction, every other pixel produces none.
// A dropped pixel does not stall the input. A kept pixel holds the input stalled while
// the pixel index, x and y are formed: they need seven products, all issued in turn
// through a single registered 24x24 multiplier under a small sequencer, and the stall
// also lasts for as long as the point output register stays stalled.
// Registers sit on an APB port at byte address 4*i and should only be written
// while the unit is idle.
module depth_pixel_unproject_unit
    import dpu_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int MAX_STRIDE  = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,

    input  wire logic                       pixel_valid,
    output logic                            pixel_stall,
    input  wire logic [DEPTH_W-1:0]         depth_sample,
    input  wire logic [COLOR_W-1:0]         red_in,
    input  wire logic [COLOR_W-1:0]         green_in,
    input  wire logic [COLOR_W-1:0]         blue_in,
    input  wire logic                       frame_start,

    output logic                            point_valid,
    input  wire logic                       point_stall,
    output logic signed [POINT_W-1:0]       point_x,
    output logic signed [POINT_W-1:0]       point_y,
    output logic      [DEPTH_W-1:0]         point_z,
    output logic      [COLOR_W-1:0]         red_out,
    output logic      [COLOR_W-1:0]         green_out,
    output logic      [COLOR_W-1:0]         blue_out,
    output logic      [INDEX_W-1:0]         pixel_index
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PHW   = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
    localparam int POSW  = (CW > RW) ? CW : RW;
    localparam int MAGW  = (POSW + 4 > CENTER_W) ? POSW + 4 : CENTER_W;
    localparam int PW    = MAGW + DEPTH_W;
    localparam int PHI_W = PW - MUL_W;
    localparam int RND_W = PROD_W + 1 - MUL_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_IDX  = 4'd1;
    localparam logic [3:0] ST_MX0  = 4'd2;
    localparam logic [3:0] ST_MX1  = 4'd3;
    localparam logic [3:0] ST_MX2  = 4'd4;
    localparam logic [3:0] ST_MY0  = 4'd5;
    localparam logic [3:0] ST_MY1  = 4'd6;
    localparam logic [3:0] ST_MY2  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    // ---------------- configuration registers ----------------
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [STRIDE_W-1:0] sample_stride_reg;
    logic [DEPTH_W-1:0]  min_depth_reg;
    logic [DEPTH_W-1:0]  max_depth_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INVF_W-1:0]   inv_focal_x_reg;
    logic [INVF_W-1:0]   inv_focal_y_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            sample_stride_reg <= RST_SAMPLE_STRIDE;
            min_depth_reg     <= RST_MIN_DEPTH;
            max_depth_reg     <= RST_MAX_DEPTH;
            center_x_reg      <= RST_CENTER_X;
            center_y_reg      <= RST_CENTER_Y;
            inv_focal_x_reg   <= RST_INV_FOCAL_X;
            inv_focal_y_reg   <= RST_INV_FOCAL_Y;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[WIDTH_W-1:0];
                REG_SAMPLE_STRIDE: sample_stride_reg <= pwdata[STRIDE_W-1:0];
                REG_MIN_DEPTH:     min_depth_reg     <= pwdata[DEPTH_W-1:0];
                REG_MAX_DEPTH:     max_depth_reg     <= pwdata[DEPTH_W-1:0];
                REG_CENTER_X:      center_x_reg      <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:      center_y_reg      <= pwdata[CENTER_W-1:0];
                REG_INV_FOCAL_X:   inv_focal_x_reg   <= pwdata[INVF_W-1:0];
                REG_INV_FOCAL_Y:   inv_focal_y_reg   <= pwdata[INVF_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:   prdata = 32'(image_width_reg);
            REG_SAMPLE_STRIDE: prdata = 32'(sample_stride_reg);
            REG_MIN_DEPTH:     prdata = 32'(min_depth_reg);
            REG_MAX_DEPTH:     prdata = 32'(max_depth_reg);
            REG_CENTER_X:      prdata = 32'(center_x_reg);
            REG_CENTER_Y:      prdata = 32'(center_y_reg);
            REG_INV_FOCAL_X:   prdata = 32'(inv_focal_x_reg);
            REG_INV_FOCAL_Y:   prdata = 32'(inv_focal_y_reg);
        endcase
    end

    // Clamped width and stride; the clamp value only wins when it fits the register
    logic [WIDTH_W-1:0]  eff_width;
    logic [STRIDE_W-1:0] eff_stride;

    always_comb
    begin
        if (image_width_reg == '0)
            eff_width = WIDTH_W'(1);
        else if (32'(image_width_reg) > 32'(MAX_COLUMNS))
            eff_width = WIDTH_W'(MAX_COLUMNS);
        else
            eff_width = image_width_reg;

        if (sample_stride_reg == '0)
            eff_stride = STRIDE_W'(1);
        else if (32'(sample_stride_reg) > 32'(MAX_STRIDE))
            eff_stride = STRIDE_W'(MAX_STRIDE);
        else
            eff_stride = sample_stride_reg;
    end

    // ---------------- raster position ----------------
    logic [CW-1:0]  col_count_reg, col_count_next;
    logic [RW-1:0]  row_count_reg, row_count_next;
    logic [PHW-1:0] col_phase_reg, col_phase_next;
    logic [PHW-1:0] row_phase_reg, row_phase_next;

    logic [CW-1:0]  cur_col;
    logic [RW-1:0]  cur_row;
    logic [PHW-1:0] cur_col_phase;
    logic [PHW-1:0] cur_row_phase;
    logic           keep;
    logic           accept;

    logic [3:0] state_reg, state_next;

    assign pixel_stall = (state_reg != ST_IDLE);
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        cur_col       = frame_start ? '0 : col_count_reg;
        cur_row       = frame_start ? '0 : row_count_reg;
        cur_col_phase = frame_start ? '0 : col_phase_reg;
        cur_row_phase = frame_start ? '0 : row_phase_reg;

        keep = (cur_col_phase == '0) && (cur_row_phase == '0) && (depth_sample != '0)
            && (depth_sample > min_depth_reg) && (depth_sample < max_depth_reg);

        if (32'(cur_col) + 32'd1 >= 32'(eff_width))
        begin
            col_count_next = '0;
            col_phase_next = '0;
            row_count_next = (32'(cur_row) + 32'd1 >= 32'(MAX_HEIGHT)) ? '0 : cur_row + 1'b1;
            row_phase_next = (32'(cur_row_phase) + 32'd1 >= 32'(eff_stride))
                ? '0 : cur_row_phase + 1'b1;
        end
        else
        begin
            col_count_next = cur_col + 1'b1;
            col_phase_next = (32'(cur_col_phase) + 32'd1 >= 32'(eff_stride))
                ? '0 : cur_col_phase + 1'b1;
            row_count_next = cur_row;
            row_phase_next = cur_row_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

    // ---------------- captured pixel ----------------
    logic [DEPTH_W-1:0] depth_reg;
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic [CW-1:0]      col_snap_reg;
    logic [RW-1:0]      row_snap_reg;
    logic [MAGW-1:0]    mag_x_reg, mag_y_reg;
    logic               neg_x_reg, neg_y_reg;

    // 16*pos - center, as sign and magnitude
    logic [MAGW:0] diff_x, diff_y;

    assign diff_x = (MAGW+1)'({cur_col, 4'b0000}) - (MAGW+1)'(center_x_reg);
    assign diff_y = (MAGW+1)'({cur_row, 4'b0000}) - (MAGW+1)'(center_y_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            depth_reg    <= depth_sample;
            red_reg      <= red_in;
            green_reg    <= green_in;
            blue_reg     <= blue_in;
            col_snap_reg <= cur_col;
            row_snap_reg <= cur_row;
            neg_x_reg    <= diff_x[MAGW];
            neg_y_reg    <= diff_y[MAGW];
            mag_x_reg    <= diff_x[MAGW] ? MAGW'(-diff_x) : diff_x[MAGW-1:0];
            mag_y_reg    <= diff_y[MAGW] ? MAGW'(-diff_y) : diff_y[MAGW-1:0];
        end
    end

    // ---------------- shared multiplier and sequencer ----------------
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod_reg;
    logic [PHI_W-1:0]  phi_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [POINT_W-1:0] x_reg;
    logic [PROD_W:0]   round_sum;
    logic [PROD_W:0]   coord_mag;
    logic              out_free;

    assign out_free  = !point_valid || !point_stall;
    // low partial product plus half LSB; the carry above bit 24 feeds the high part
    assign round_sum = {1'b0, prod_reg} + 49'h0_0080_0000;
    assign coord_mag = {1'b0, prod_reg} + (PROD_W+1)'(rnd_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDX:
            begin
                mul_a = MUL_W'(row_snap_reg);
                mul_b = MUL_W'(eff_width);
            end
            ST_MX0:
            begin
                mul_a = MUL_W'(mag_x_reg);
                mul_b = MUL_W'(depth_reg);
            end
            ST_MX1:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = inv_focal_x_reg;
            end
            ST_MX2:
            begin
                mul_a = MUL_W'(phi_reg);
                mul_b = inv_focal_x_reg;
            end
            ST_MY0:
            begin
                mul_a = MUL_W'(mag_y_reg);
                mul_b = MUL_W'(depth_reg);
            end
            ST_MY1:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = inv_focal_y_reg;
            end
            ST_MY2:
            begin
                mul_a = MUL_W'(phi_reg);
                mul_b = inv_focal_y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != ST_IDLE && state_reg != ST_DONE)
            prod_reg <= mul_a * mul_b;

        unique case (state_reg)
            ST_MX0:          index_reg <= prod_reg[INDEX_W-1:0] + INDEX_W'(col_snap_reg);
            ST_MX1, ST_MY1:  phi_reg   <= prod_reg[PW-1:MUL_W];
            ST_MX2, ST_MY2:  rnd_reg   <= round_sum[PROD_W:MUL_W];
            ST_MY0:          x_reg     <= saturate_point(coord_mag, neg_x_reg);
            default:         ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && keep) state_next = ST_IDX;
            ST_IDX:  state_next = ST_MX0;
            ST_MX0:  state_next = ST_MX1;
            ST_MX1:  state_next = ST_MX2;
            ST_MX2:  state_next = ST_MY0;
            ST_MY0:  state_next = ST_MY1;
            ST_MY1:  state_next = ST_MY2;
            ST_MY2:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- output register ----------------
    logic load_out;
    logic point_valid_reg, point_valid_next;

    assign load_out = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        if (load_out)
            point_valid_next = 1'b1;
        else if (!point_stall)
            point_valid_next = 1'b0;
        else
            point_valid_next = point_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_valid_reg <= 1'b0;
        else
            point_valid_reg <= point_valid_next;
    end

    assign point_valid = point_valid_reg;

    logic [POINT_W-1:0] point_x_reg, point_y_reg;
    logic [DEPTH_W-1:0] point_z_reg;
    logic [COLOR_W-1:0] red_out_reg, green_out_reg, blue_out_reg;
    logic [INDEX_W-1:0] pixel_index_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            point_x_reg     <= x_reg;
            point_y_reg     <= saturate_point(coord_mag, neg_y_reg);
            point_z_reg     <= depth_reg;
            red_out_reg     <= red_reg;
            green_out_reg   <= green_reg;
            blue_out_reg    <= blue_reg;
            pixel_index_reg <= index_reg;
        end
    end

    assign point_x     = $signed(point_x_reg);
    assign point_y     = $signed(point_y_reg);
    assign point_z     = point_z_reg;
    assign red_out     = red_out_reg;
    assign green_out   = green_out_reg;
    assign blue_out    = blue_out_reg;
    assign pixel_index = pixel_index_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for depth_pixel_unproject_unit: pixel stream in, checked points out.
`timescale 1ns / 1ps

module tb_top;
    import dpu_pkg::*;

    localparam int MAX_COLUMNS         = 4096;
    localparam int MAX_HEIGHT          = 4096;
    localparam int MAX_STRIDE          = 16;
    localparam int SETTLE_CYCLES       = 24;
    localparam int RANDOM_PHASE_PIXELS = 170;

    typedef struct {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic [INDEX_W-1:0] idx;
    } point_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      pixel_valid = 1'b0;
    logic                      pixel_stall;
    logic [DEPTH_W-1:0]        depth_sample = '0;
    logic [COLOR_W-1:0]        red_in = '0;
    logic [COLOR_W-1:0]        green_in = '0;
    logic [COLOR_W-1:0]        blue_in = '0;
    logic                      frame_start = 1'b0;
    logic                      point_valid;
    logic                      point_stall = 1'b0;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic [COLOR_W-1:0]        red_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        blue_out;
    logic [INDEX_W-1:0]        pixel_index;

    // Shadow registers and raster state of the prediction
    logic [WIDTH_W-1:0]  cfg_width = RST_IMAGE_WIDTH;
    logic [STRIDE_W-1:0] cfg_stride = RST_SAMPLE_STRIDE;
    logic [DEPTH_W-1:0]  cfg_min = RST_MIN_DEPTH;
    logic [DEPTH_W-1:0]  cfg_max = RST_MAX_DEPTH;
    logic [CENTER_W-1:0] cfg_cx = RST_CENTER_X;
    logic [CENTER_W-1:0] cfg_cy = RST_CENTER_Y;
    logic [INVF_W-1:0]   cfg_fx = RST_INV_FOCAL_X;
    logic [INVF_W-1:0]   cfg_fy = RST_INV_FOCAL_Y;
    logic [11:0]         raster_col = '0;
    logic [11:0]         raster_row = '0;
    logic [3:0]          col_phase = '0;
    logic [3:0]          row_phase = '0;

    point_t pending_points[$];
    int     err_cnt = 0;
    int     pixels_in = 0;
    int     points_checked = 0;
    int     reg_writes = 0;
    bit     gaps_on = 1'b1;
    int     hold_len = 0;

    depth_pixel_unproject_unit #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_STRIDE  (MAX_STRIDE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .depth_sample (depth_sample),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .frame_start  (frame_start),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .pixel_index  (pixel_index)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("depth_pixel_unproject_unit regression: fail");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > MAX_COLUMNS)
            return MAX_COLUMNS;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_stride();
        if (cfg_stride == 0)
            return 1;
        if (cfg_stride > MAX_STRIDE)
            return MAX_STRIDE;
        return cfg_stride;
    endfunction

    // (16*pos - center) * depth * inv_f / 2^24, rounded half away from zero, saturated
    function automatic logic [POINT_W-1:0] axis_coord(input logic [11:0] pos,
                                                      input logic [CENTER_W-1:0] ctr,
                                                      input logic [DEPTH_W-1:0] dep,
                                                      input logic [INVF_W-1:0] invf);
        logic [63:0] scaled;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] m;
        logic        neg;
        scaled = {52'd0, pos} * 64'd16;
        neg = scaled < {48'd0, ctr};
        mag = neg ? ({48'd0, ctr} - scaled) : (scaled - {48'd0, ctr});
        prod = mag * {48'd0, dep} * {40'd0, invf};
        m = (prod + (64'd1 << 23)) >> 24;
        if (neg)
        begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            m = 64'd0 - m;
            return m[POINT_W-1:0];
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return m[POINT_W-1:0];
    endfunction

    // Judges one accepted pixel, queues its point if kept, then steps the raster position
    function automatic void unproject_pixel(input logic [DEPTH_W-1:0] dep,
                                            input logic [COLOR_W-1:0] r,
                                            input logic [COLOR_W-1:0] g,
                                            input logic [COLOR_W-1:0] b,
                                            input logic fs);
        int unsigned w;
        int unsigned s;
        point_t      p;
        w = eff_width();
        s = eff_stride();
        if (fs)
        begin
            raster_col = '0;
            raster_row = '0;
            col_phase = '0;
            row_phase = '0;
        end
        if (col_phase == 0 && row_phase == 0 && dep != 0 && dep > cfg_min && dep < cfg_max)
        begin
            p.x = axis_coord(raster_col, cfg_cx, dep, cfg_fx);
            p.y = axis_coord(raster_row, cfg_cy, dep, cfg_fy);
            p.z = dep;
            p.r = r;
            p.g = g;
            p.b = b;
            p.idx = INDEX_W'(raster_row * w + raster_col);
            pending_points.push_back(p);
        end
        if (raster_col + 32'd1 >= w)
        begin
            raster_col = '0;
            col_phase = '0;
            raster_row = (raster_row + 32'd1 >= MAX_HEIGHT) ? 12'd0 : raster_row + 12'd1;
            row_phase = (row_phase + 32'd1 >= s) ? 4'd0 : row_phase + 4'd1;
        end
        else
        begin
            raster_col = raster_col + 12'd1;
            col_phase = (col_phase + 32'd1 >= s) ? 4'd0 : col_phase + 4'd1;
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Input acceptance feeds the prediction; output acceptance is checked against it
    always @(posedge clk)
    begin
        point_t want;
        if (pixel_valid === 1'b1 && pixel_stall === 1'b0)
        begin
            unproject_pixel(depth_sample, red_in, green_in, blue_in, frame_start);
            pixels_in++;
        end
        if (point_valid === 1'b1 && point_stall === 1'b0)
        begin
            if (pending_points.size() == 0)
            begin
                $error("point transaction with no expected point pending");
                err_cnt++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("point_x", want.x, $unsigned(point_x));
                check_field("point_y", want.y, $unsigned(point_y));
                check_field("point_z", want.z, point_z);
                check_field("red_out", want.r, red_out);
                check_field("green_out", want.g, green_out);
                check_field("blue_out", want.b, blue_out);
                check_field("pixel_index", want.idx, pixel_index);
                points_checked++;
            end
        end
    end

    // Output side: long hold-off when requested, otherwise random stalls while gaps are on
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            point_stall <= 1'b1;
            hold_len--;
        end
        else
            point_stall <= gaps_on && ($urandom_range(99) < 30);
    end

    task automatic send_pixel(input logic [DEPTH_W-1:0] dep, input logic [COLOR_W-1:0] r,
                              input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
                              input logic fs);
        if (gaps_on && $urandom_range(99) < 30)
        begin
            repeat ($urandom_range(1, 3))
            begin
                @(negedge clk);
                pixel_valid <= 1'b0;
            end
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        depth_sample <= dep;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        frame_start <= fs;
        do
            @(posedge clk);
        while (pixel_stall !== 1'b0);
    endtask

    task automatic send_depth(input logic [DEPTH_W-1:0] dep, input logic fs);
        send_pixel(dep, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), fs);
    endtask

    // Block idle: input lowered, all points back, pipeline given time to empty
    task automatic drain();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width = val[WIDTH_W-1:0];
            REG_SAMPLE_STRIDE: cfg_stride = val[STRIDE_W-1:0];
            REG_MIN_DEPTH:     cfg_min = val[DEPTH_W-1:0];
            REG_MAX_DEPTH:     cfg_max = val[DEPTH_W-1:0];
            REG_CENTER_X:      cfg_cx = val[CENTER_W-1:0];
            REG_CENTER_Y:      cfg_cy = val[CENTER_W-1:0];
            REG_INV_FOCAL_X:   cfg_fx = val[INVF_W-1:0];
            REG_INV_FOCAL_Y:   cfg_fy = val[INVF_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_regs(input logic [31:0] w, input logic [31:0] s,
                                input logic [31:0] mn, input logic [31:0] mx,
                                input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] fx, input logic [31:0] fy);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_SAMPLE_STRIDE, s);
        write_reg(REG_MIN_DEPTH, mn);
        write_reg(REG_MAX_DEPTH, mx);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_INV_FOCAL_X, fx);
        write_reg(REG_INV_FOCAL_Y, fy);
    endtask

    function automatic logic [31:0] pick_center();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'd65535;
            2: return $urandom_range(0, 1024);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_inv_focal();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFF_FFFF;
            2: return $urandom & 32'hFF_FFFF;
            default: return $urandom_range(20000, 60000);
        endcase
    endfunction

    task automatic random_config();
        logic [31:0] w;
        logic [31:0] s;
        logic [31:0] mn;
        logic [31:0] mx;
        case ($urandom_range(9))
            0: w = 0;
            1: w = 1;
            2: w = MAX_COLUMNS;
            3: w = $urandom_range(MAX_COLUMNS + 1, 8191);
            default: w = $urandom_range(2, 40);
        endcase
        case ($urandom_range(7))
            0: s = 0;
            1: s = MAX_STRIDE;
            2: s = $urandom_range(MAX_STRIDE + 1, 31);
            3: s = 1;
            default: s = $urandom_range(2, 4);
        endcase
        case ($urandom_range(19))
            0: mn = 65535;
            1, 2: mn = $urandom_range(0, 65535);
            3, 4, 5, 6, 7: mn = $urandom_range(0, 3000);
            default: mn = 0;
        endcase
        case ($urandom_range(19))
            0: mx = 0;
            1, 2: mx = $urandom_range(0, 65535);
            3, 4, 5, 6, 7: mx = $urandom_range(3000, 65535);
            default: mx = 65535;
        endcase
        program_regs(w, s, mn, mx, pick_center(), pick_center(), pick_inv_focal(),
                     pick_inv_focal());
    endtask

    // Mostly depths inside the window, with invalid, boundary and unconstrained ones mixed in
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int lo;
        int hi;
        int r;
        lo = int'(cfg_min) + 1;
        hi = int'(cfg_max) - 1;
        r = $urandom_range(99);
        if (r < 70 && lo <= hi)
            return DEPTH_W'($urandom_range(lo, hi));
        if (r < 80)
            return '0;
        if (r < 88)
            return DEPTH_W'($urandom);
        if (r < 94)
            return cfg_min;
        return cfg_max;
    endfunction

    task automatic test_reset_config();
        send_pixel(16'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(16'd1, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(16'd65535, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(16'd65534, 8'd0, 8'd255, 8'd0, 1'b0);
        drain();
    endtask

    task automatic test_depth_window();
        program_regs(4, 1, 100, 200, 32, 16, 40000, 50000);
        send_depth(16'd100, 1'b1);
        send_depth(16'd101, 1'b0);
        send_depth(16'd199, 1'b0);
        send_depth(16'd200, 1'b0);
        send_depth(16'd0, 1'b0);
        drain();
    endtask

    task automatic test_negative_saturation();
        program_regs(16, 1, 0, 65535, 65535, 65535, 32'hFF_FFFF, 32'hFF_FFFF);
        send_depth(16'd65534, 1'b1);
        send_depth(16'd65534, 1'b0);
        drain();
    endtask

    // Width and stride registers at zero, at their limits and above their limits
    task automatic test_size_extremes();
        program_regs(0, 0, 0, 65535, 16, 16, 32'h10_0000, 32'h10_0000);
        send_depth(16'd300, 1'b1);
        send_depth(16'd301, 1'b0);
        send_depth(16'd302, 1'b0);
        drain();
        program_regs(8191, 31, 0, 65535, 30000, 20000, 30000, 30000);
        send_depth(16'd1500, 1'b1);
        send_depth(16'd1500, 1'b0);
        drain();
        program_regs(MAX_COLUMNS, MAX_STRIDE, 0, 65535, 65535, 0, 31957, 31957);
        send_depth(16'd2500, 1'b1);
        send_depth(16'd2500, 1'b0);
        drain();
    endtask

    task automatic test_frame_restart();
        program_regs(4, 2, 0, 65535, 24, 8, 31957, 31957);
        send_depth(16'd700, 1'b1);
        repeat (4) send_depth(16'd700, 1'b0);
        send_depth(16'd900, 1'b1);
        send_depth(16'd900, 1'b0);
        drain();
    endtask

    // Registers shrunk under a raster position that lies past the new limits
    task automatic test_counter_beyond_limit();
        program_regs(8, 4, 0, 65535, 64, 32, 31957, 31957);
        send_depth(16'd500, 1'b1);
        repeat (5) send_depth(16'd500, 1'b0);
        drain();
        program_regs(4, 2, 0, 65535, 64, 32, 31957, 31957);
        repeat (6) send_depth(16'd500, 1'b0);
        drain();
        program_regs(1, 8, 0, 65535, 64, 32, 31957, 31957);
        send_depth(16'd800, 1'b1);
        repeat (4) send_depth(16'd800, 1'b0);
        drain();
        write_reg(REG_SAMPLE_STRIDE, 2);
        repeat (3) send_depth(16'd800, 1'b0);
        drain();
    endtask

    // Output held off long enough for the block to back up into its input
    task automatic test_backpressure();
        program_regs(16, 1, 0, 65535, 128, 64, 31957, 31957);
        gaps_on = 1'b0;
        @(posedge clk);
        hold_len = 400;
        send_depth(16'd1000, 1'b1);
        repeat (49) send_depth(DEPTH_W'($urandom_range(1, 65534)), 1'b0);
        drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int          sent;
        int unsigned w;
        int          len;
        bit          clean;
        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            gaps_on = (ph != 3);
            sent = 0;
            while (sent < RANDOM_PHASE_PIXELS)
            begin
                w = eff_width();
                len = int'((w <= 40) ? w * $urandom_range(1, 8) : $urandom_range(1, 160));
                if (len > RANDOM_PHASE_PIXELS - sent)
                    len = RANDOM_PHASE_PIXELS - sent;
                clean = $urandom_range(9) < 8;
                for (int i = 0; i < len; i++)
                    send_pixel(pick_depth(), COLOR_W'($urandom), COLOR_W'($urandom),
                               COLOR_W'($urandom),
                               clean ? (i == 0) : ($urandom_range(49) == 0));
                sent += len;
            end
            drain();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        test_depth_window();
        test_negative_saturation();
        test_size_extremes();
        test_frame_restart();
        test_counter_beyond_limit();
        test_backpressure();
        test_random_frames();

        $display("Run covered %0d pixels, %0d points checked, %0d register writes",
                 pixels_in, points_checked, reg_writes);
        $display("Directed edges, long output hold-off and random frames done");
        if (err_cnt == 0)
            $display("depth_pixel_unproject_unit regression: pass");
        else
            $display("depth_pixel_unproject_unit regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
src/dpu_pkg.sv
src/depth_pixel_unproject_unit.sv
tb/sv/tb_top.sv
